// ----- hw/rtl/cfi_pkg.sv -----
// Shared widths and register codes for the cloud-in-cell force interpolator.
package cfi_pkg;

  localparam int POS_W    = 32;
  localparam int FORCE_W  = 32;
  localparam int INV_W    = 32;
  localparam int CELL_W   = 6;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam int CWGT_W   = 2 * FRAC_W + 1;
  localparam int ACC_W    = 2 * FORCE_W;
  localparam int ENTRY_W  = 2 * FORCE_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(1) << FRAC_W;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_INV_CELL_WIDTH  = 1'b0;
  localparam cfg_index_t CFG_INV_CELL_HEIGHT = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- hw/rtl/cic_force_interpolator_2d.sv -----
// Top level of the cloud-in-cell force interpolator on a periodic 2D grid.
// A write transaction stores one cell in the grid memory.
// A query transaction stalls the input until its result enters the output register; the
// result comes from four corner reads through the single memory port plus scaling,
// multiply and accumulate stages, and no new item is taken while the query is in progress.
// Synchronous reset clears the control state and loads both reciprocals with 1.0;
// the grid memory is not cleared and a cell holds garbage until it is written.
module cic_force_interpolator_2d #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_wr,
  input  cfi_pkg::cfg_index_t               cfg_index,
  input  logic [cfi_pkg::INV_W-1:0]         cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic signed [cfi_pkg::POS_W-1:0]  pos_x,
  input  logic signed [cfi_pkg::POS_W-1:0]  pos_y,
  input  logic [cfi_pkg::CELL_W-1:0]        cell_col,
  input  logic [cfi_pkg::CELL_W-1:0]        cell_row,
  input  logic signed [cfi_pkg::FORCE_W-1:0] load_force_x,
  input  logic signed [cfi_pkg::FORCE_W-1:0] load_force_y,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cfi_pkg::FORCE_W-1:0] force_x,
  output logic signed [cfi_pkg::FORCE_W-1:0] force_y
);
  import cfi_pkg::*;

  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int PROD_W = FORCE_W + CWGT_W + 1;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GATHER = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration registers.
  logic [INV_W-1:0] inv_cell_width;
  logic [INV_W-1:0] inv_cell_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_width  <= INV_RESET;
      inv_cell_height <= INV_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_INV_CELL_WIDTH:  inv_cell_width  <= cfg_data;
        CFG_INV_CELL_HEIGHT: inv_cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The block takes a new transaction only when the sequencer is idle.
  logic in_accept;
  logic query_start;
  logic write_start;

  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign query_start = in_accept && (mode == MODE_QUERY);
  assign write_start = in_accept && (mode == MODE_WRITE);

  // Scaling stage: base cell and fractions are registered at query acceptance.
  logic [COL_W-1:0]  base_col;
  logic [ROW_W-1:0]  base_row;
  logic [FRAC_W-1:0] frac_x;
  logic [FRAC_W-1:0] frac_y;

  cfi_scale #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_scale (
    .clk    (clk),
    .load   (query_start),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .inv_x  (inv_cell_width),
    .inv_y  (inv_cell_height),
    .col    (base_col),
    .row    (base_row),
    .frac_x (frac_x),
    .frac_y (frac_y)
  );

  // Write address: the cell indices are wrapped to the grid size.
  logic [CELL_W+COL_W-1:0] wr_col_ext;
  logic [CELL_W+ROW_W-1:0] wr_row_ext;
  logic [ADDR_W-1:0]       wr_addr;

  assign wr_col_ext = (CELL_W + COL_W)'(cell_col);
  assign wr_row_ext = (CELL_W + ROW_W)'(cell_row);
  assign wr_addr    = {wr_col_ext[COL_W-1:0], wr_row_ext[ROW_W-1:0]};

  // Corner sequencing: corner index bit 1 steps the column, bit 0 the row.
  logic [1:0]          corner;
  logic                corner_dx;
  logic                corner_dy;
  logic [COL_W-1:0]    rd_col;
  logic [ROW_W-1:0]    rd_row;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic [WEIGHT_W-1:0] weight_x;
  logic [WEIGHT_W-1:0] weight_y;
  logic [2*WEIGHT_W-1:0] weight_prod;

  assign corner_dx = corner[1];
  assign corner_dy = corner[0];
  assign rd_en     = (state == ST_GATHER);

  // Column and row sums wrap naturally at the power-of-two grid size.
  assign rd_col  = base_col + COL_W'(corner_dx);
  assign rd_row  = base_row + ROW_W'(corner_dy);
  assign rd_addr = {rd_col, rd_row};

  assign weight_x    = corner_dx ? WEIGHT_W'(frac_x) : (WEIGHT_ONE - WEIGHT_W'(frac_x));
  assign weight_y    = corner_dy ? WEIGHT_W'(frac_y) : (WEIGHT_ONE - WEIGHT_W'(frac_y));
  assign weight_prod = weight_x * weight_y;

  // Grid memory: one force pair per entry, force_y in the upper half.
  logic [ENTRY_W-1:0] grid_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (write_start) begin
      grid_mem[wr_addr] <= {load_force_y, load_force_x};
    end
    if (rd_en) begin
      rd_data <= grid_mem[rd_addr];
    end
  end

  // Read stage: corner weight travels alongside the memory read.
  logic              rd_valid;
  logic              rd_last;
  logic [CWGT_W-1:0] corner_weight;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      corner_weight <= weight_prod[CWGT_W-1:0];
    end
  end

  // Multiply stage.
  logic signed [PROD_W-1:0] mul_x;
  logic signed [PROD_W-1:0] mul_y;
  logic                     prod_valid;
  logic                     prod_last;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  prod_y;

  assign mul_x = $signed(rd_data[FORCE_W-1:0]) * $signed({1'b0, corner_weight});
  assign mul_y = $signed(rd_data[ENTRY_W-1:FORCE_W]) * $signed({1'b0, corner_weight});

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod_x <= mul_x[ACC_W-1:0];
      prod_y <= mul_y[ACC_W-1:0];
    end
  end

  // Accumulate stage. The weights sum to one, so the sum never leaves 64 bits.
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;

  always_ff @(posedge clk) begin
    if (query_start) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (prod_valid) begin
      acc_x <= acc_x + prod_x;
      acc_y <= acc_y + prod_y;
    end
  end

  // Pipeline control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      corner     <= '0;
    end else begin
      rd_valid   <= rd_en;
      rd_last    <= rd_en && (corner == 2'd3);
      prod_valid <= rd_valid;
      prod_last  <= rd_valid && rd_last;
      if (query_start) begin
        corner <= '0;
      end else if (rd_en) begin
        corner <= corner + 2'd1;
      end
    end
  end

  // The output register frees when its transaction is taken, so a finished
  // result can move in during the same cycle.
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_start) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (corner == 2'd3) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_valid && prod_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: floor of the Q16.48 sum is its upper 32 bits.
  logic out_load;

  assign out_load = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      force_x <= acc_x[ACC_W-1:FORCE_W];
      force_y <= acc_y[ACC_W-1:FORCE_W];
    end
  end

endmodule

// ----- hw/rtl/cfi_scale.sv -----
// Scales a query position to grid units and splits it into cell index and fraction.
module cfi_scale #(
  parameter int COL_W = 6,
  parameter int ROW_W = 6
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic signed [cfi_pkg::POS_W-1:0] pos_x,
  input  logic signed [cfi_pkg::POS_W-1:0] pos_y,
  input  logic [cfi_pkg::INV_W-1:0]        inv_x,
  input  logic [cfi_pkg::INV_W-1:0]        inv_y,
  output logic [COL_W-1:0]                 col,
  output logic [ROW_W-1:0]                 row,
  output logic [cfi_pkg::FRAC_W-1:0]       frac_x,
  output logic [cfi_pkg::FRAC_W-1:0]       frac_y
);
  import cfi_pkg::*;

  localparam int PROD_W = POS_W + INV_W + 1;

  logic signed [PROD_W-1:0] scaled_x;
  logic signed [PROD_W-1:0] scaled_y;

  // Signed position times unsigned reciprocal gives an exact Q32.32 value.
  assign scaled_x = $signed(pos_x) * $signed({1'b0, inv_x});
  assign scaled_y = $signed(pos_y) * $signed({1'b0, inv_y});

  // The integer part is truncated to the grid width, which is the periodic wrap.
  always_ff @(posedge clk) begin
    if (load) begin
      col    <= scaled_x[2*FRAC_W+COL_W-1:2*FRAC_W];
      row    <= scaled_y[2*FRAC_W+ROW_W-1:2*FRAC_W];
      frac_x <= scaled_x[2*FRAC_W-1:FRAC_W];
      frac_y <= scaled_y[2*FRAC_W-1:FRAC_W];
    end
  end

endmodule
